// ===== sv/psd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the Prufer sequence decoder: the payload
// width and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Width of a node label on both channels
    localparam int CODE_W = 7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // store the accepted item, read its count if in range
        logic inc;      // write back the incremented count
        logic start;    // build the initial leaf map, rewind the step index
        logic rd_seq;   // read the stored value of the current step
        logic rd_cnt;   // read the count of that value
        logic upd;      // emit one edge, update count and leaf map
        logic err_out;  // emit the single error result
        logic clear;    // return the run state to its reset value
    } psd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;       // sequence store holds its capacity
        logic in_range;   // input value is a valid count address
        logic run_err;    // stored sequence has a bad value
        logic last_step;  // current step emits the final edge
        logic out_free;   // output register can take a result
    } psd_sts_t;

endpackage

// ===== sv/psd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/psd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_ctrl
// Controller: sequences loading, the run check and the per-edge decode steps.
// ----------------------------------------------------------------------------
module psd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_last,
    input  psd_pkg::psd_sts_t  sts,
    output psd_pkg::psd_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INC    = 3'd1;
    localparam logic [2:0] ST_CHK    = 3'd2;
    localparam logic [2:0] ST_ERR    = 3'd3;
    localparam logic [2:0] ST_RD_SEQ = 3'd4;
    localparam logic [2:0] ST_RD_CNT = 3'd5;
    localparam logic [2:0] ST_UPD    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.full) begin
                        // drop the item; a dropped last item rejects the run
                        if (s_is_last) begin
                            state_next = ST_ERR;
                        end
                    end else begin
                        cmd.load  = 1'b1;
                        last_next = s_is_last;
                        if (sts.in_range) begin
                            state_next = ST_INC;
                        end else if (s_is_last) begin
                            state_next = ST_CHK;
                        end
                    end
                end
            end
            ST_INC: begin
                cmd.inc    = 1'b1;
                state_next = last_reg ? ST_CHK : ST_IDLE;
            end
            ST_CHK: begin
                if (sts.run_err) begin
                    state_next = ST_ERR;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_RD_SEQ;
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.err_out = 1'b1;
                    cmd.clear   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD_SEQ: begin
                cmd.rd_seq = 1'b1;
                state_next = ST_RD_CNT;
            end
            ST_RD_CNT: begin
                cmd.rd_cnt = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (sts.out_free) begin
                    cmd.upd = 1'b1;
                    if (sts.last_step) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD_SEQ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== sv/psd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_datapath
// Datapath: sequence and count memories, leaf map with its priority encoder,
// run check and the output register.
// ----------------------------------------------------------------------------
module psd_datapath #(
    parameter int MAX_NODES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psd_pkg::psd_cmd_t             cmd,
    output psd_pkg::psd_sts_t             sts,
    input  logic [psd_pkg::CODE_W-1:0]    s_code_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psd_pkg::CODE_W-1:0]    m_leaf_node,
    output logic [psd_pkg::CODE_W-1:0]    m_parent_node,
    output logic                          m_bad_input,
    output logic                          m_last_edge
);

    localparam int CW      = psd_pkg::CODE_W;
    localparam int SEQ_CAP = MAX_NODES - 1;
    localparam int LEN_W   = $clog2(MAX_NODES);
    localparam int SEQ_AW  = (SEQ_CAP > 1) ? $clog2(SEQ_CAP) : 1;
    localparam int CNT_AW  = LEN_W;
    localparam int CNT_W   = LEN_W;

    // run state
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     k_reg, k_next;
    logic [CW-1:0]        max_reg, max_next;
    logic                 zero_reg, zero_next;
    logic [MAX_NODES-1:0] vld_reg, vld_next;
    logic [MAX_NODES-1:0] leaf_reg, leaf_next;
    logic [CNT_AW-1:0]    cnt_addr_reg, cnt_addr_next;
    logic [CW-1:0]        parent_reg, parent_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [CW-1:0]        m_leaf_reg, m_leaf_next;
    logic [CW-1:0]        m_parent_reg, m_parent_next;
    logic                 m_bad_reg, m_bad_next;
    logic                 m_last_reg, m_last_next;

    logic [CW-1:0]        seq_rd;
    logic [CNT_W-1:0]     cnt_rd, cnt_eff, cnt_wr;
    logic [CW-1:0]        in_m1, seq_m1, n_val;
    logic [CNT_AW-1:0]    cnt_rd_addr;
    logic                 cnt_rd_en, cnt_wr_en;
    logic [CNT_AW-1:0]    leaf_idx;
    logic                 leaf_found;
    logic [CW-1:0]        leaf_node;

    assign in_m1  = s_code_value - CW'(1);
    assign seq_m1 = seq_rd - CW'(1);
    assign n_val  = CW'(len_reg) + CW'(1);

    assign sts.full      = (len_reg == LEN_W'(SEQ_CAP));
    assign sts.in_range  = (s_code_value != '0) && (s_code_value <= CW'(MAX_NODES));
    assign sts.run_err   = zero_reg || (max_reg > n_val);
    assign sts.last_step = (LEN_W'(k_reg + LEN_W'(1)) == len_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    psd_ram #(
        .WIDTH (CW),
        .DEPTH (SEQ_CAP)
    ) u_seq_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load),
        .wr_addr (len_reg[SEQ_AW-1:0]),
        .wr_data (s_code_value),
        .rd_en   (cmd.rd_seq),
        .rd_addr (k_reg[SEQ_AW-1:0]),
        .rd_data (seq_rd)
    );

    // counts read as zero until written in this run
    assign cnt_rd_en   = (cmd.load && sts.in_range) || cmd.rd_cnt;
    assign cnt_rd_addr = cmd.rd_cnt ? seq_m1[CNT_AW-1:0] : in_m1[CNT_AW-1:0];
    assign cnt_eff     = vld_reg[cnt_addr_reg] ? cnt_rd : '0;
    assign cnt_wr_en   = cmd.inc || cmd.upd;

    always_comb begin
        if (cmd.inc) begin
            cnt_wr = cnt_eff + CNT_W'(1);
        end else if (cnt_eff != '0) begin
            cnt_wr = cnt_eff - CNT_W'(1);
        end else begin
            cnt_wr = '0;
        end
    end

    psd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_NODES)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_addr_reg),
        .wr_data (cnt_wr),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd)
    );

    // lowest set bit of the leaf map
    always_comb begin
        leaf_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (leaf_reg[i]) begin
                leaf_idx = CNT_AW'(i);
            end
        end
        leaf_found = |leaf_reg;
        leaf_node  = leaf_found ? (CW'(leaf_idx) + CW'(1)) : '0;
    end

    always_comb begin
        len_next      = len_reg;
        k_next        = k_reg;
        max_next      = max_reg;
        zero_next     = zero_reg;
        vld_next      = vld_reg;
        leaf_next     = leaf_reg;
        cnt_addr_next = cnt_addr_reg;
        parent_next   = parent_reg;

        if (cmd.load) begin
            len_next      = len_reg + LEN_W'(1);
            cnt_addr_next = in_m1[CNT_AW-1:0];
            if (s_code_value > max_reg) begin
                max_next = s_code_value;
            end
            if (s_code_value == '0) begin
                zero_next = 1'b1;
            end
        end
        if (cmd.inc) begin
            vld_next[cnt_addr_reg] = 1'b1;
        end
        if (cmd.start) begin
            k_next = '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                leaf_next[i] = (LEN_W'(i) <= len_reg) && !vld_reg[i];
            end
        end
        if (cmd.rd_cnt) begin
            parent_next   = seq_rd;
            cnt_addr_next = seq_m1[CNT_AW-1:0];
        end
        if (cmd.upd) begin
            k_next = k_reg + LEN_W'(1);
            if (leaf_found) begin
                leaf_next[leaf_idx] = 1'b0;
            end
            if (cnt_eff == CNT_W'(1)) begin
                leaf_next[cnt_addr_reg] = 1'b1;
            end
        end
        if (cmd.clear) begin
            len_next  = '0;
            max_next  = '0;
            zero_next = 1'b0;
            vld_next  = '0;
            leaf_next = '0;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_leaf_next   = m_leaf_reg;
        m_parent_next = m_parent_reg;
        m_bad_next    = m_bad_reg;
        m_last_next   = m_last_reg;
        if (cmd.upd) begin
            m_valid_next  = 1'b1;
            m_leaf_next   = leaf_node;
            m_parent_next = parent_reg;
            m_bad_next    = 1'b0;
            m_last_next   = sts.last_step;
        end else if (cmd.err_out) begin
            m_valid_next  = 1'b1;
            m_leaf_next   = '0;
            m_parent_next = '0;
            m_bad_next    = 1'b1;
            m_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            max_reg     <= '0;
            zero_reg    <= 1'b0;
            vld_reg     <= '0;
            leaf_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            max_reg     <= max_next;
            zero_reg    <= zero_next;
            vld_reg     <= vld_next;
            leaf_reg    <= leaf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        cnt_addr_reg <= cnt_addr_next;
        parent_reg   <= parent_next;
        m_leaf_reg   <= m_leaf_next;
        m_parent_reg <= m_parent_next;
        m_bad_reg    <= m_bad_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_leaf_node   = m_leaf_reg;
    assign m_parent_node = m_parent_reg;
    assign m_bad_input   = m_bad_reg;
    assign m_last_edge   = m_last_reg;

endmodule

// ===== sv/prufer_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prufer_sequence_decoder
// Decodes a Prufer-style sequence (length n-1, last value is the root) into
// the edge list of its tree, one edge per result item.
// ----------------------------------------------------------------------------
// Feed the code values one item at a time and mark the final one with
// s_is_last; that item starts the decode. Each loaded value is written into
// the sequence memory; a value in 1..MAX_NODES also gets a read-modify-write
// of its count in the count memory. A value arriving when MAX_NODES-1 values
// are already stored is dropped. After the last item the run is checked,
// then each edge is made in order: read the stored value, read its count,
// then update count and leaf map and pick the smallest leaf with a priority
// encoder over the leaf map. Edges come out in sequence order, the final one
// flagged by m_last_edge. If any stored value is 0 or larger than n, or the
// sequence overflowed, the run yields one result with m_bad_input and
// m_last_edge set and both node fields zero. State returns to reset after
// every run; per-node valid bits make the count memory read as zero, so no
// clearing pass is needed. The next run can load while the last result still
// waits in the output register.
// ----------------------------------------------------------------------------
module prufer_sequence_decoder #(
    parameter int MAX_NODES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items: one code value each
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [psd_pkg::CODE_W-1:0]    s_code_value,
    input  logic                          s_is_last,
    // result items: one edge each, or one error result
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psd_pkg::CODE_W-1:0]    m_leaf_node,
    output logic [psd_pkg::CODE_W-1:0]    m_parent_node,
    output logic                          m_bad_input,
    output logic                          m_last_edge
);

    psd_pkg::psd_cmd_t cmd;
    psd_pkg::psd_sts_t sts;

    // Sequencer: load, check, then step through the edges
    psd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_is_last (s_is_last),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage, leaf tracking and the output register
    psd_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_code_value  (s_code_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_leaf_node   (m_leaf_node),
        .m_parent_node (m_parent_node),
        .m_bad_input   (m_bad_input),
        .m_last_edge   (m_last_edge)
    );

endmodule

// ===== sv/psd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [psd_pkg::CODE_W-1:0]    m_leaf_node,
    input logic [psd_pkg::CODE_W-1:0]    m_parent_node,
    input logic                          m_bad_input,
    input logic                          m_last_edge
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_leaf_node) &&
        $stable(m_parent_node) && $stable(m_bad_input) && $stable(m_last_edge))
        else $error("stalled result changed");

    // error result ends the run and carries no nodes
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_input |-> m_last_edge && m_leaf_node == '0 &&
        m_parent_node == '0)
        else $error("malformed error result");

    // an edge joins two distinct real nodes
    a_edge_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_input |-> m_parent_node != '0 &&
        m_leaf_node != '0 && m_leaf_node != m_parent_node)
        else $error("malformed edge");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind prufer_sequence_decoder psd_checker u_psd_checker (.*);
